// ===== sv/grid_box_mean_stencil_macros.svh =====
// ----------------------------------------------------------------------------
// grid_box_mean_stencil assertion macros
// Shorthand for clocked assertions disabled by an active-low reset.
// ----------------------------------------------------------------------------
`ifndef GRID_BOX_MEAN_STENCIL_MACROS_SVH
`define GRID_BOX_MEAN_STENCIL_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define GBMS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define GBMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/gbms_pkg.sv =====
// ----------------------------------------------------------------------------
// gbms_pkg
// Shared types and constants of the 3x3 box mean stencil.
// ----------------------------------------------------------------------------
`default_nettype none

package gbms_pkg;

  // cell values and configuration
  localparam int VALUE_BITS = 16;
  localparam int CFG_W      = 11;

  // column sum of three cells, window sum of nine cells plus rounding bias
  localparam int CS_W  = VALUE_BITS + 2;
  localparam int SUM_W = VALUE_BITS + 4;

  // exact division by reciprocal for any dividend below 2**SUM_W
  localparam int MUL_W   = SUM_W + 1;
  localparam int PROD_W  = SUM_W + MUL_W;
  localparam int DIV6_SH = SUM_W + 3;
  localparam int DIV9_SH = SUM_W + 4;
  localparam logic [MUL_W-1:0] DIV6_MUL = MUL_W'(((64'd1 << DIV6_SH) + 64'd5) / 64'd6);
  localparam logic [MUL_W-1:0] DIV9_MUL = MUL_W'(((64'd1 << DIV9_SH) + 64'd8) / 64'd9);

  // divisor codes
  localparam logic [1:0] DIV_BY_4 = 2'd0;
  localparam logic [1:0] DIV_BY_6 = 2'd1;
  localparam logic [1:0] DIV_BY_9 = 2'd2;

  // queue between front and back, and the result queue
  localparam int MQ_DEPTH = 4;
  localparam int MQ_CNT_W = $clog2(MQ_DEPTH + 1);
  localparam int OQ_DEPTH = 8;
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef logic [VALUE_BITS-1:0] value_t;

  // per-item classification made by the front
  typedef struct packed {
    logic has_out;     // item completes a result
    logic top_ok;      // top row of this column lies in the grid
    logic bot_ok;      // bottom row of this column lies in the grid
    logic left_ok;     // left window column lies in the grid
    logic right_ok;    // right window column lies in the grid
    logic frame_last;  // result is the last cell of the grid
  } item_flags_t;

  // one new window column with its flags
  typedef struct packed {
    value_t      top;
    value_t      mid;
    value_t      cur;
    item_flags_t flags;
  } mq_item_t;

  typedef struct packed {
    value_t mean;
    logic   frame_last;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/gbms_fifo.sv =====
// ----------------------------------------------------------------------------
// gbms_fifo
// Small register queue with fall-through read and an occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none

module gbms_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         wr_en,
  input  wire logic [WIDTH-1:0]             wr_data,
  input  wire logic                         rd_en,
  output logic      [WIDTH-1:0]             rd_data,
  output logic                              empty,
  output logic      [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(wr_en) - CNT_W'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data = mem[rd_ptr_r];
  assign empty   = (count_r == '0);
  assign count   = count_r;

endmodule

`default_nettype wire

// ===== sv/gbms_front.sv =====
// ----------------------------------------------------------------------------
// gbms_front
// Raster position tracking, item classification and the two line buffers.
// ----------------------------------------------------------------------------
`default_nettype none

module gbms_front #(
  parameter int MAX_SIZE = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [gbms_pkg::CFG_W-1:0]     cfg_grid_size,
  input  wire logic                           push,
  input  wire logic                           req_type,
  input  wire gbms_pkg::value_t               cell_value,
  output logic                                full,
  input  wire logic [gbms_pkg::MQ_CNT_W-1:0]  mq_count,
  output logic                                mq_wr_en,
  output gbms_pkg::mq_item_t                  mq_item
);

  import gbms_pkg::*;

  localparam int CW       = $clog2(MAX_SIZE);
  localparam int RW       = $clog2(MAX_SIZE + 2);
  localparam int NW       = $clog2(MAX_SIZE + 1);
  localparam int CMP_W    = (NW > CFG_W) ? NW : CFG_W;
  localparam int RST_SIZE = (MAX_SIZE < 1024) ? MAX_SIZE : 1024;

  logic [NW-1:0]   n_r;
  logic [RW-1:0]   row_r, row_nxt;
  logic [CW-1:0]   col_r, col_nxt;

  logic            s1_valid_r;
  logic [CW-1:0]   s1_col_r;
  value_t          s1_cur_r;
  item_flags_t     s1_flags_r;
  value_t          top_rd_r;
  value_t          mid_rd_r;
  logic            byp_r;
  value_t          byp_val_r;

  value_t          upper_mem  [MAX_SIZE];
  value_t          middle_mem [MAX_SIZE];

  logic [MQ_CNT_W:0] pending;
  logic [CMP_W-1:0]  cfg_ext;
  logic [NW-1:0]     size_clamped;
  logic [RW-1:0]     last_row;
  logic              flushing;
  logic              accept;
  logic              proc;
  value_t            cur_v;
  item_flags_t       flags;

  // room for the item in flight plus the new one
  assign pending = (MQ_CNT_W + 1)'(mq_count) + (MQ_CNT_W + 1)'(s1_valid_r);
  assign full    = (pending >= (MQ_CNT_W + 1)'(MQ_DEPTH));

  // drains during the data phase are dropped, pushes while flushing act as drains
  assign flushing = (row_r >= RW'(n_r));
  assign accept   = push & ~full;
  assign proc     = accept & (flushing | ~req_type);
  assign cur_v    = flushing ? '0 : cell_value;
  assign last_row = RW'(n_r) + RW'(1);

  // classification of the item at the current raster position
  always_comb begin
    flags.has_out    = (row_r >= RW'(2)) || ((row_r == RW'(1)) && (col_r != '0));
    flags.top_ok     = (row_r != RW'(1));
    flags.bot_ok     = ~flushing;
    flags.left_ok    = (col_r != CW'(1));
    flags.right_ok   = (col_r != '0);
    flags.frame_last = (row_r == last_row);
  end

  // raster position advance
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (row_r == last_row) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (col_r == CW'(n_r - NW'(1))) begin
      row_nxt = row_r + RW'(1);
      col_nxt = '0;
    end else begin
      col_nxt = col_r + CW'(1);
    end
  end

  // grid size clamp
  always_comb begin
    cfg_ext = CMP_W'(cfg_grid_size);
    if (cfg_ext < CMP_W'(2)) begin
      size_clamped = NW'(2);
    end else if (cfg_ext > CMP_W'(MAX_SIZE)) begin
      size_clamped = NW'(MAX_SIZE);
    end else begin
      size_clamped = NW'(cfg_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r   <= NW'(RST_SIZE);
      row_r <= '0;
      col_r <= '0;
    end else if (cfg_wr_en) begin
      n_r   <= size_clamped;
      row_r <= '0;
      col_r <= '0;
    end else if (proc) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // middle line: read old row, store the new cell
  always_ff @(posedge clk) begin
    if (proc) begin
      mid_rd_r          <= middle_mem[col_r];
      middle_mem[col_r] <= cur_v;
    end
  end

  // upper line: read now, rewrite with the middle value in the cycle after
  always_ff @(posedge clk) begin
    if (proc) begin
      top_rd_r <= upper_mem[col_r];
    end
    if (s1_valid_r) begin
      upper_mem[s1_col_r] <= mid_rd_r;
    end
  end

  // forward the pending upper write when the next item hits the same column
  always_ff @(posedge clk) begin
    if (proc) begin
      byp_r     <= s1_valid_r && (s1_col_r == col_r);
      byp_val_r <= mid_rd_r;
    end
  end

  // read stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= proc;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      s1_col_r   <= col_r;
      s1_cur_r   <= cur_v;
      s1_flags_r <= flags;
    end
  end

  // hand the new window column to the back
  assign mq_wr_en      = s1_valid_r;
  assign mq_item.top   = byp_r ? byp_val_r : top_rd_r;
  assign mq_item.mid   = mid_rd_r;
  assign mq_item.cur   = s1_cur_r;
  assign mq_item.flags = s1_flags_r;

endmodule

`default_nettype wire

// ===== sv/gbms_back.sv =====
// ----------------------------------------------------------------------------
// gbms_back
// Sliding window of column sums, masked window sum and rounded division.
// ----------------------------------------------------------------------------
`default_nettype none

module gbms_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           mq_empty,
  input  wire gbms_pkg::mq_item_t             mq_item,
  output logic                                mq_rd_en,
  input  wire logic [gbms_pkg::OQ_CNT_W-1:0]  oq_count,
  output logic                                oq_wr_en,
  output gbms_pkg::result_t                   oq_data
);

  import gbms_pkg::*;

  logic [OQ_CNT_W:0] credit;
  logic              take;
  logic [CS_W-1:0]   col_sum;

  logic [CS_W-1:0]   cs0_r, cs1_r, cs2_r;
  logic              cs2_rows3_r;
  logic              b1_valid_r;
  logic              b1_left_r, b1_right_r, b1_rows3_r, b1_last_r;

  logic [SUM_W-1:0]  win_sum;
  logic [1:0]        div_code;
  logic [SUM_W-1:0]  bias;
  logic [SUM_W-1:0]  b2_x_r;
  logic [1:0]        b2_code_r;
  logic              b2_last_r;
  logic              b2_valid_r;

  logic [MUL_W-1:0]  mul_sel;
  logic [PROD_W-1:0] prod;
  value_t            quot;
  value_t            b3_mean_r;
  logic              b3_last_r;
  logic              b3_valid_r;

  // take an item only with a result slot reserved for everything in flight
  assign credit   = (OQ_CNT_W + 1)'(oq_count) + (OQ_CNT_W + 1)'(b1_valid_r)
                  + (OQ_CNT_W + 1)'(b2_valid_r) + (OQ_CNT_W + 1)'(b3_valid_r);
  assign take     = ~mq_empty && (credit < (OQ_CNT_W + 1)'(OQ_DEPTH));
  assign mq_rd_en = take;

  // sum of the in-grid cells of the new column
  assign col_sum = (mq_item.flags.top_ok ? CS_W'(mq_item.top) : '0)
                 + CS_W'(mq_item.mid)
                 + (mq_item.flags.bot_ok ? CS_W'(mq_item.cur) : '0);

  // window shift, the row coverage of the center column sets the divisor
  always_ff @(posedge clk) begin
    if (take) begin
      cs0_r       <= cs1_r;
      cs1_r       <= cs2_r;
      cs2_r       <= col_sum;
      cs2_rows3_r <= mq_item.flags.top_ok & mq_item.flags.bot_ok;
      b1_left_r   <= mq_item.flags.left_ok;
      b1_right_r  <= mq_item.flags.right_ok;
      b1_rows3_r  <= cs2_rows3_r;
      b1_last_r   <= mq_item.flags.frame_last;
    end
  end

  // window sum and divisor choice
  always_comb begin
    win_sum = (b1_left_r ? SUM_W'(cs0_r) : '0) + SUM_W'(cs1_r)
            + (b1_right_r ? SUM_W'(cs2_r) : '0);
    if (b1_rows3_r && b1_left_r && b1_right_r) begin
      div_code = DIV_BY_9;
    end else if (b1_rows3_r || (b1_left_r && b1_right_r)) begin
      div_code = DIV_BY_6;
    end else begin
      div_code = DIV_BY_4;
    end
    case (div_code)
      DIV_BY_4: bias = SUM_W'(2);
      DIV_BY_6: bias = SUM_W'(3);
      DIV_BY_9: bias = SUM_W'(4);
      default:  bias = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (b1_valid_r) begin
      b2_x_r    <= win_sum + bias;
      b2_code_r <= div_code;
      b2_last_r <= b1_last_r;
    end
  end

  // rounded quotient: shift for four, reciprocal multiply for six and nine
  assign mul_sel = (b2_code_r == DIV_BY_9) ? DIV9_MUL : DIV6_MUL;
  assign prod    = PROD_W'(b2_x_r) * PROD_W'(mul_sel);

  always_comb begin
    case (b2_code_r)
      DIV_BY_4: quot = VALUE_BITS'(b2_x_r >> 2);
      DIV_BY_6: quot = VALUE_BITS'(prod >> DIV6_SH);
      DIV_BY_9: quot = VALUE_BITS'(prod >> DIV9_SH);
      default:  quot = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (b2_valid_r) begin
      b3_mean_r <= quot;
      b3_last_r <= b2_last_r;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r <= 1'b0;
      b2_valid_r <= 1'b0;
      b3_valid_r <= 1'b0;
    end else begin
      b1_valid_r <= take & mq_item.flags.has_out;
      b2_valid_r <= b1_valid_r;
      b3_valid_r <= b2_valid_r;
    end
  end

  assign oq_wr_en           = b3_valid_r;
  assign oq_data.mean       = b3_mean_r;
  assign oq_data.frame_last = b3_last_r;

endmodule

`default_nettype wire

// ===== sv/grid_box_mean_stencil.sv =====
// ----------------------------------------------------------------------------
// grid_box_mean_stencil
// Edge-normalized 3x3 box mean over a square grid streamed in raster order.
// ----------------------------------------------------------------------------
// One transaction in and one result out per clock while the reader keeps up.
// Cells enter in raster order; each result is the rounded mean of the in-grid
// cells around the cell one row and one column behind the input, so a frame
// of n x n cells is finished by n+1 drain transactions (pushes during that
// phase count as drains, drains during the data phase are dropped). A result
// reaches the output queue once the transaction that completes it has
// passed the line buffer read (a single port per line buffer), the
// front-to-back queue, then column sum, window sum and the reciprocal
// multiply. Writing grid_size restarts the frame; write it only while idle.
// The line buffers need no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_box_mean_stencil #(
  parameter int MAX_SIZE = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [gbms_pkg::CFG_W-1:0]  cfg_grid_size,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic                        in_req_type,
  input  wire gbms_pkg::value_t            in_cell_value,
  output logic                             empty,
  input  wire logic                        pop,
  output gbms_pkg::value_t                 out_mean_value,
  output logic                             out_frame_last
);

  import gbms_pkg::*;

  logic                    mq_wr_en;
  mq_item_t                mq_wr_item;
  logic [$bits(mq_item_t)-1:0] mq_rd_data;
  mq_item_t                mq_rd_item;
  logic                    mq_rd_en;
  logic                    mq_empty;
  logic [MQ_CNT_W-1:0]     mq_count;

  logic                    oq_wr_en;
  result_t                 oq_wr_data;
  logic [$bits(result_t)-1:0] oq_rd_data;
  result_t                 oq_rd_item;
  logic [OQ_CNT_W-1:0]     oq_count;

  // front: position, classification, line buffers
  gbms_front #(
    .MAX_SIZE (MAX_SIZE)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_grid_size (cfg_grid_size),
    .push          (push),
    .req_type      (in_req_type),
    .cell_value    (in_cell_value),
    .full          (full),
    .mq_count      (mq_count),
    .mq_wr_en      (mq_wr_en),
    .mq_item       (mq_wr_item)
  );

  // queue between front and back
  gbms_fifo #(
    .WIDTH ($bits(mq_item_t)),
    .DEPTH (MQ_DEPTH)
  ) u_mid_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mq_wr_en),
    .wr_data (mq_wr_item),
    .rd_en   (mq_rd_en),
    .rd_data (mq_rd_data),
    .empty   (mq_empty),
    .count   (mq_count)
  );

  assign mq_rd_item = mq_item_t'(mq_rd_data);

  // back: window, sum, divide
  gbms_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .mq_empty (mq_empty),
    .mq_item  (mq_rd_item),
    .mq_rd_en (mq_rd_en),
    .oq_count (oq_count),
    .oq_wr_en (oq_wr_en),
    .oq_data  (oq_wr_data)
  );

  // result queue
  gbms_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OQ_DEPTH)
  ) u_out_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (oq_wr_en),
    .wr_data (oq_wr_data),
    .rd_en   (pop & ~empty),
    .rd_data (oq_rd_data),
    .empty   (empty),
    .count   (oq_count)
  );

  assign oq_rd_item     = result_t'(oq_rd_data);
  assign out_mean_value = oq_rd_item.mean;
  assign out_frame_last = oq_rd_item.frame_last;

endmodule

`default_nettype wire

// ===== sv/gbms_checker.sv =====
// ----------------------------------------------------------------------------
// gbms_checker
// Port-level checks of the box mean stencil, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "grid_box_mean_stencil_macros.svh"

module gbms_checker (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic             full,
  input  wire logic             pop,
  input  wire logic             empty,
  input  wire gbms_pkg::value_t out_mean_value,
  input  wire logic             out_frame_last
);

  // both queues come out of reset empty
  `GBMS_ASSERT_SAME(a_reset_idle, clk, rst_n, !$past(rst_n), empty && !full, "not idle after reset")

  // backpressure only builds up through an accepted transaction
  `GBMS_ASSERT_SAME(a_full_needs_push, clk, rst_n, $rose(full), $past(push && !full), "full rose without a transaction")

  // a waiting result holds until it is taken
  `GBMS_ASSERT_NEXT(a_result_holds, clk, rst_n, !empty && !pop, !empty && $stable(out_mean_value) && $stable(out_frame_last), "waiting result changed")

endmodule

bind grid_box_mean_stencil gbms_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .push           (push),
  .full           (full),
  .pop            (pop),
  .empty          (empty),
  .out_mean_value (out_mean_value),
  .out_frame_last (out_frame_last)
);

`default_nettype wire

// ===== bench/grid_box_mean_stencil_test.sv =====
// ----------------------------------------------------------------------------
// grid_box_mean_stencil_test
// Self-checking bench for the edge-normalized 3x3 box mean stencil.
// ----------------------------------------------------------------------------
// Streams square grids in raster order through the queue-style input port and
// predicts every mean and frame-last flag with an independent line buffer
// model. Covers the smallest grid, the clamped and reset grid sizes, drains
// during the data phase, pushes during the flush phase and frames cut short
// by a size write, then random frames with bursty input and a stalling reader.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_box_mean_stencil_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gbms_pkg::*;

  localparam int CLK_PERIOD        = 20;
  localparam int RESET_CYCLES      = 11;
  localparam int GRID_MAX          = 1024;
  localparam int SETTLE_CYCLES     = 16;
  localparam int WATCHDOG_LIMIT    = 1000;
  localparam int MAX_REPORTS       = 10;
  localparam int ITEMS_GOAL        = 1750;
  localparam int RESET_FRAME_ITEMS = 64;

  // request codes
  localparam logic REQ_CELL  = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  // block ports
  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               cfg_wr_en     = 1'b0;
  logic [CFG_W-1:0]   cfg_grid_size = '0;
  logic               push          = 1'b0;
  logic               full;
  logic               in_req_type   = REQ_CELL;
  value_t             in_cell_value = '0;
  logic               empty;
  logic               pop           = 1'b0;
  value_t             out_mean_value;
  logic               out_frame_last;

  // handshakes sampled mid-cycle, used at the next rising edge
  logic               in_take   = 1'b0;
  logic               out_take  = 1'b0;
  value_t             seen_mean = '0;
  logic               seen_last = 1'b0;

  // stencil model state
  value_t             upper_row  [GRID_MAX];
  value_t             middle_row [GRID_MAX];
  value_t             window_px  [3][3];   // [column][row]
  int unsigned        grid_n;
  int unsigned        row_pos;
  int unsigned        col_pos;
  result_t            pending_means [$];

  int                 mismatches  = 0;
  int                 items_sent  = 0;
  int                 burst_left  = 0;
  int                 idle_cycles = 0;

  // receiver stall pattern
  int                 seg_left   = 0;
  int                 stall_mode = 0;
  logic [3:0]         phase      = '0;

  grid_box_mean_stencil #(
    .MAX_SIZE(GRID_MAX)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_grid_size  (cfg_grid_size),
    .push           (push),
    .full           (full),
    .in_req_type    (in_req_type),
    .in_cell_value  (in_cell_value),
    .empty          (empty),
    .pop            (pop),
    .out_mean_value (out_mean_value),
    .out_frame_last (out_frame_last)
  );

  // clock
  always #(CLK_PERIOD / 2) clk = ~clk;

  // sample both channels where everything is settled
  always @(negedge clk) begin
    in_take   <= push && !full;
    out_take  <= pop && !empty;
    seen_mean <= out_mean_value;
    seen_last <= out_frame_last;
  end

  // advance the model by one accepted input transaction
  task automatic advance_stencil(input logic req, input value_t val);
    int unsigned n, r, c, ro, co, r0, r1, c0, c1, sum, cnt, i, j;
    value_t      v, top, mid;
    bit          flushing, has_out;
    result_t     res;
    n = grid_n;
    r = row_pos;
    c = col_pos;
    flushing = (r >= n);
    // drains are dropped while cells are still expected
    if (!flushing && req == REQ_DRAIN) return;
    v = flushing ? value_t'(0) : val;

    // rotate line buffers at this column
    top = upper_row[c];
    mid = middle_row[c];
    upper_row[c]  = mid;
    middle_row[c] = v;

    // slide the window one column
    for (i = 0; i < 3; i++) begin
      window_px[0][i] = window_px[1][i];
      window_px[1][i] = window_px[2][i];
    end
    window_px[2][0] = top;
    window_px[2][1] = mid;
    window_px[2][2] = v;

    // mean of the in-grid part of the window, ties round up
    has_out = (r >= 2) || (r == 1 && c >= 1);
    if (has_out) begin
      if (c >= 1) begin
        ro = r - 1;
        co = c - 1;
      end else begin
        ro = r - 2;
        co = n - 1;
      end
      r0 = (ro > 0) ? 0 : 1;
      r1 = (ro + 1 < n) ? 2 : 1;
      c0 = (co > 0) ? 0 : 1;
      c1 = (co + 1 < n) ? 2 : 1;
      sum = 0;
      for (j = c0; j <= c1; j++)
        for (i = r0; i <= r1; i++)
          sum += 32'(window_px[j][i]);
      cnt = (r1 - r0 + 1) * (c1 - c0 + 1);
      res.mean       = value_t'((2 * sum + cnt) / (2 * cnt));
      res.frame_last = (r == n + 1);
      pending_means.push_back(res);
    end

    // raster position, wrap after the flush
    if (r >= n + 1) begin
      row_pos = 0;
      col_pos = 0;
    end else begin
      c++;
      if (c >= n) begin
        c = 0;
        r++;
      end
      row_pos = r;
      col_pos = c;
    end
  endtask

  function automatic value_t random_cell();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return value_t'($urandom);
  endfunction

  // one input transaction, with bursts and random gaps
  task automatic send_item(input logic req, input value_t val, input bit counted);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      if ($urandom_range(0, 9) >= 3) begin
        gap = $urandom_range(1, 10);
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push          <= 1'b1;
    in_req_type   <= req;
    in_cell_value <= val;
    @(posedge clk);
    while (!in_take) @(posedge clk);
    advance_stencil(req, val);
    if (counted) items_sent++;
  endtask

  // grid size write once everything has drained
  task automatic set_grid(input logic [CFG_W-1:0] size_word);
    push <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en     <= 1'b1;
    cfg_grid_size <= size_word;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (size_word < 2) grid_n = 2;
    else if (size_word > GRID_MAX) grid_n = GRID_MAX;
    else grid_n = 32'(size_word);
    row_pos = 0;
    col_pos = 0;
  endtask

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch %0s: expected %0d actual %0d", what, want, got);
  endtask

  // check each result transaction against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_take) begin
      if (pending_means.size() == 0) begin
        flag_mismatch("result with none pending, mean", 0, 32'(seen_mean));
      end else begin
        want = pending_means.pop_front();
        if (seen_mean !== want.mean)
          flag_mismatch("mean_value", 32'(want.mean), 32'(seen_mean));
        if (seen_last !== want.frame_last)
          flag_mismatch("frame_last", 32'(want.frame_last), 32'(seen_last));
      end
    end
  end

  // reader stalls: always ready, mostly ready, mostly stalled, square wave
  always @(posedge clk) begin
    if (!rst_n) begin
      pop      <= 1'b0;
      seg_left <= 0;
    end else begin
      if (seg_left == 0) begin
        seg_left   <= $urandom_range(16, 256);
        stall_mode <= $urandom_range(0, 3);
      end else begin
        seg_left <= seg_left - 1;
      end
      case (stall_mode)
        0:       pop <= 1'b1;
        1:       pop <= ($urandom_range(0, 3) != 0);
        2:       pop <= ($urandom_range(0, 3) == 0);
        default: pop <= phase[3];
      endcase
      phase <= phase + 1'b1;
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst_n || in_take || out_take) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // partial frame at the reset size, cut off before any result is due
  task automatic test_reset_size();
    int k;
    for (k = 0; k < RESET_FRAME_ITEMS; k++) begin
      if ($urandom_range(0, 49) == 0) send_item(REQ_DRAIN, random_cell(), 0);
      send_item(REQ_CELL, random_cell(), 1);
    end
  endtask

  // size below range acts as 2, extremes and a rounding tie
  task automatic test_smallest_grid();
    set_grid('0);
    send_item(REQ_CELL, '0, 1);
    send_item(REQ_CELL, '1, 1);
    send_item(REQ_DRAIN, '1, 0);
    send_item(REQ_CELL, '1, 1);
    send_item(REQ_CELL, '0, 1);
    // flush, the push counts as a drain
    send_item(REQ_CELL, '1, 1);
    send_item(REQ_DRAIN, '0, 1);
    send_item(REQ_DRAIN, '0, 1);
    // size one also acts as 2, all cells at the top value
    set_grid(11'd1);
    repeat (4) send_item(REQ_CELL, '1, 1);
    repeat (3) send_item(REQ_DRAIN, '0, 1);
  endtask

  // corners, edges and the interior cell on a 3x3 grid
  task automatic test_three_grid();
    int k;
    set_grid(11'd3);
    for (k = 0; k < 9; k++)
      send_item(REQ_CELL, (k % 2 == 0) ? value_t'('1) : value_t'(0), 1);
    send_item(REQ_DRAIN, '0, 1);
    send_item(REQ_CELL, 16'h1234, 1);
    send_item(REQ_DRAIN, '1, 1);
    send_item(REQ_CELL, '1, 1);
  endtask

  // size above range acts as the largest grid
  task automatic test_clamp_high();
    int k;
    set_grid('1);
    for (k = 0; k < GRID_MAX + 20; k++) send_item(REQ_CELL, random_cell(), 1);
  endtask

  // random frames, mostly small, some repeated, some cut short
  task automatic test_random_frames();
    int          pick, k, lim;
    int unsigned n, cells;
    bit          need_write, abort;
    logic [CFG_W-1:0] word;
    need_write = 1'b1;
    while (items_sent < ITEMS_GOAL) begin
      if (need_write || $urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) word = CFG_W'($urandom_range(0, 1));
        else if (pick < 80) word = CFG_W'($urandom_range(2, 8));
        else if (pick < 96) word = CFG_W'($urandom_range(9, 32));
        else word = CFG_W'($urandom_range(33, 64));
        set_grid(word);
        need_write = 1'b0;
      end
      n     = grid_n;
      cells = n * n;
      abort = ($urandom_range(0, 9) == 0);
      lim   = abort ? $urandom_range(1, cells - 1) : cells;
      for (k = 0; k < lim; k++) begin
        if ($urandom_range(0, 19) == 0) send_item(REQ_DRAIN, random_cell(), 0);
        send_item(REQ_CELL, random_cell(), 1);
      end
      if (abort) begin
        need_write = 1'b1;
      end else begin
        for (k = 0; k <= n; k++) begin
          if ($urandom_range(0, 3) == 0) send_item(REQ_CELL, random_cell(), 1);
          else send_item(REQ_DRAIN, random_cell(), 1);
        end
      end
    end
  endtask

  initial begin
    // model after reset
    foreach (upper_row[i]) begin
      upper_row[i]  = '0;
      middle_row[i] = '0;
    end
    foreach (window_px[i, j]) window_px[i][j] = '0;
    grid_n  = GRID_MAX;
    row_pos = 0;
    col_pos = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_size();
    test_smallest_grid();
    test_three_grid();
    test_clamp_high();
    test_random_frames();

    // let the tail drain
    push <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
